### rtl/core/hrlp_pkg.sv
package hrlp_pkg;

    // Request word: one byte of the request line
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } request_t;

    // Result word: one per request byte
    typedef struct packed {
        logic [7:0] out_char;
        logic [1:0] out_kind;
        logic       done_res;
        logic [2:0] status;
    } result_t;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_PATH  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BAD     = 3'd1,
        ST_METHOD  = 3'd2,
        ST_NOTIMPL = 3'd3,
        ST_VERSION = 3'd4
    } status_t;

    typedef enum logic [8:0] {
        PH_BEFORE_M = 9'b000000001,
        PH_IN_M     = 9'b000000010,
        PH_BEFORE_P = 9'b000000100,
        PH_IN_P     = 9'b000001000,
        PH_IN_Q     = 9'b000010000,
        PH_BEFORE_V = 9'b000100000,
        PH_IN_V     = 9'b001000000,
        PH_AFTER_V  = 9'b010000000,
        PH_ENDED    = 9'b100000000
    } phase_t;

    localparam logic [7:0] CH_ZERO  = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    localparam int METHOD_LEN  = 3;
    localparam int VERSION_LEN = 10;

    // Entry 0 is the first byte of each token
    localparam logic [METHOD_LEN-1:0][7:0] METHOD_TEXT = {8'h54, 8'h45, 8'h47};
    localparam logic [VERSION_LEN-1:0][7:0] VERSION_TEXT = {
        8'h0A, 8'h0D, 8'h31, 8'h2E, 8'h31, 8'h2F, 8'h50, 8'h54, 8'h54, 8'h48
    };

    // Classified byte handed from front to back
    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic        is_zero;
        logic        is_space;
        logic        is_slash;
        logic        is_qmark;
        logic        is_quote;
        logic [3:0]  meth_eq;   // bit k: ch matches method byte k, zero past the end
        logic [15:0] ver_eq;    // bit k: ch matches version byte k, zero past the end
    } class_t;

endpackage

### rtl/core/hrlp_fifo.sv
module hrlp_fifo
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 2
    )
    (
        input  logic             clk,
        input  logic             rst_n,
        input  logic             push,
        input  logic [WIDTH-1:0] wr_data,
        output logic             full,
        input  logic             pop,
        output logic [WIDTH-1:0] rd_data,
        output logic             empty
    );

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/core/hrlp_front.sv
module hrlp_front
    import hrlp_pkg::*;
    (
        input  request_t request,
        output class_t   cls
    );

    always_comb
    begin
        cls          = '0;
        cls.ch       = request.ch;
        cls.last     = request.last;
        cls.is_zero  = (request.ch == CH_ZERO);
        cls.is_space = (request.ch == CH_SPACE);
        cls.is_slash = (request.ch == CH_SLASH);
        cls.is_qmark = (request.ch == CH_QMARK);
        cls.is_quote = (request.ch == CH_QUOTE);
        // Compare against every position of the fixed tokens at once
        for (int k = 0; k < METHOD_LEN; k++)
        begin
            cls.meth_eq[k] = (request.ch == METHOD_TEXT[k]);
        end
        for (int k = 0; k < VERSION_LEN; k++)
        begin
            cls.ver_eq[k] = (request.ch == VERSION_TEXT[k]);
        end
    end

endmodule

### rtl/core/hrlp_back.sv
module hrlp_back
    import hrlp_pkg::*;
    #(
        parameter int OUT_DEPTH = 2
    )
    (
        input  logic    clk,
        input  logic    rst_n,
        input  class_t  cls,
        input  logic    cls_empty,
        output logic    cls_pop,
        output result_t result,
        output logic    empty,
        input  logic    pop
    );

    phase_t     phase_reg, phase_next;
    logic [3:0] pos_reg, pos_next;
    logic       tok_ok_reg, tok_ok_next;
    status_t    err_reg, err_next;
    result_t    res;
    logic       out_full;
    logic       step;

    assign step    = !cls_empty && !out_full;
    assign cls_pop = step;

    always_comb
    begin
        phase_t     p;
        logic [3:0] mp;
        logic       tk;
        status_t    e;
        logic       m_full, v_full;

        p      = phase_reg;
        mp     = pos_reg;
        tk     = tok_ok_reg;
        e      = err_reg;
        m_full = 1'b0;
        v_full = 1'b0;
        res    = '0;

        if ((e == ST_OK) && (p != PH_ENDED))
        begin
            if (cls.is_zero)
            begin
                m_full = tk && (mp == 4'(METHOD_LEN));
                v_full = tk && (mp == 4'(VERSION_LEN));
                unique case (p)
                    PH_IN_M:    e = m_full ? ST_BAD : ST_METHOD;
                    PH_IN_V:    e = v_full ? ST_OK : ST_VERSION;
                    PH_AFTER_V: e = ST_OK;
                    default:    e = ST_BAD;
                endcase
                p = PH_ENDED;
            end
            else if (cls.is_space)
            begin
                m_full = tk && (mp == 4'(METHOD_LEN));
                v_full = tk && (mp == 4'(VERSION_LEN));
                unique case (p)
                    PH_IN_M:
                    begin
                        if (!m_full)
                        begin
                            e = ST_METHOD;
                        end
                        p = PH_BEFORE_P;
                    end
                    PH_IN_P, PH_IN_Q:
                    begin
                        p = PH_BEFORE_V;
                    end
                    PH_IN_V:
                    begin
                        if (!v_full)
                        begin
                            e = ST_VERSION;
                        end
                        p = PH_AFTER_V;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                // Match flags are zero past the token end, so a hit also bounds the position
                unique case (p)
                    PH_BEFORE_M, PH_IN_M:
                    begin
                        if (p == PH_BEFORE_M)
                        begin
                            tk = 1'b1;
                            mp = '0;
                        end
                        p = PH_IN_M;
                        if (tk && cls.meth_eq[mp[1:0]] && (mp < 4'(METHOD_LEN)))
                        begin
                            mp = mp + 1'b1;
                        end
                        else
                        begin
                            tk = 1'b0;
                        end
                    end
                    PH_BEFORE_P:
                    begin
                        if (!cls.is_slash)
                        begin
                            e = ST_NOTIMPL;
                        end
                        else
                        begin
                            res.out_kind = KIND_PATH;
                            res.out_char = cls.ch;
                            p = PH_IN_P;
                        end
                    end
                    PH_IN_P:
                    begin
                        if (cls.is_quote)
                        begin
                            e = ST_BAD;
                        end
                        else if (cls.is_qmark)
                        begin
                            p = PH_IN_Q;
                        end
                        else
                        begin
                            res.out_kind = KIND_PATH;
                            res.out_char = cls.ch;
                        end
                    end
                    PH_IN_Q:
                    begin
                        if (cls.is_quote)
                        begin
                            e = ST_BAD;
                        end
                        else
                        begin
                            res.out_kind = KIND_QUERY;
                            res.out_char = cls.ch;
                        end
                    end
                    PH_BEFORE_V, PH_IN_V:
                    begin
                        if (p == PH_BEFORE_V)
                        begin
                            tk = 1'b1;
                            mp = '0;
                        end
                        p = PH_IN_V;
                        if (tk && cls.ver_eq[mp])
                        begin
                            mp = mp + 1'b1;
                        end
                        else
                        begin
                            tk = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        if (cls.last)
        begin
            // Close out a line that ended without a zero byte
            if ((e == ST_OK) && (p != PH_ENDED))
            begin
                m_full = tk && (mp == 4'(METHOD_LEN));
                v_full = tk && (mp == 4'(VERSION_LEN));
                unique case (p)
                    PH_IN_M:    e = m_full ? ST_BAD : ST_METHOD;
                    PH_IN_V:    e = v_full ? ST_OK : ST_VERSION;
                    PH_AFTER_V: e = ST_OK;
                    default:    e = ST_BAD;
                endcase
            end
            res.done_res = 1'b1;
            res.status   = e;
            p  = PH_BEFORE_M;
            mp = '0;
            tk = 1'b1;
            e  = ST_OK;
        end

        phase_next  = p;
        pos_next    = mp;
        tok_ok_next = tk;
        err_next    = e;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_BEFORE_M;
            pos_reg    <= '0;
            tok_ok_reg <= 1'b1;
            err_reg    <= ST_OK;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            tok_ok_reg <= tok_ok_next;
            err_reg    <= err_next;
        end
    end

    hrlp_fifo
        #(
            .WIDTH ($bits(result_t)),
            .DEPTH (OUT_DEPTH)
        )
        u_out_q
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .push    (step),
            .wr_data (res),
            .full    (out_full),
            .pop     (pop),
            .rd_data (result),
            .empty   (empty)
        );

endmodule

### rtl/core/http_request_line_parser.sv
// Channel  | Handshake           | Word
// ---------+---------------------+----------------------------------------------
// request  | push / full         | ch, last: one byte of the request line
// result   | empty / pop         | out_char, out_kind, done_res, status
//
// One result word for each request word, in order. A byte is stored in the
// classifier queue, the line state machine steps on it as it leaves that queue,
// and its result word is stored in the result queue until it is popped.
// Throughput is one word per cycle while neither side stalls,
// as the line state machine steps on one word at a time.
// Reset clears both queues and returns the parser to the start of a line.
// A stalled result side fills the result queue, then the classifier queue, and
// then raises full; either side may stall without loss.
module http_request_line_parser
    import hrlp_pkg::*;
    #(
        parameter int MID_DEPTH = 2,
        parameter int OUT_DEPTH = 2
    )
    (
        input  logic     clk,
        input  logic     rst_n,
        input  logic     push,
        input  request_t request,
        output logic     full,
        input  logic     pop,
        output result_t  result,
        output logic     empty
    );

    class_t cls_in;
    class_t cls_out;
    logic   cls_empty;
    logic   cls_pop;

    // Classify the byte before it enters the queue
    hrlp_front u_front
    (
        .request (request),
        .cls     (cls_in)
    );

    // Decouple classification from the line state machine
    hrlp_fifo
        #(
            .WIDTH ($bits(class_t)),
            .DEPTH (MID_DEPTH)
        )
        u_mid_q
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .push    (push),
            .wr_data (cls_in),
            .full    (full),
            .pop     (cls_pop),
            .rd_data (cls_out),
            .empty   (cls_empty)
        );

    // Advance the line state and hold results for the consumer
    hrlp_back
        #(
            .OUT_DEPTH (OUT_DEPTH)
        )
        u_back
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .cls       (cls_out),
            .cls_empty (cls_empty),
            .cls_pop   (cls_pop),
            .result    (result),
            .empty     (empty),
            .pop       (pop)
        );

endmodule

### rtl/core/hrlp_checker.sv
module hrlp_checker
    import hrlp_pkg::*;
    (
        input logic    clk,
        input logic    rst_n,
        input logic    pop,
        input logic    empty,
        input result_t result
    );

    // Hold a waiting word until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result word changed while waiting");

    // No byte value without a byte kind
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((result.out_kind == KIND_NONE && result.out_char == 8'd0)
                    || result.out_kind == KIND_PATH || result.out_kind == KIND_QUERY))
        else $error("bad out_kind or stray out_char");

    // Status only on the word that closes a line
    a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.done_res) |-> (result.status == ST_OK))
        else $error("status set on a word that does not close the line");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.done_res) |-> (result.status == ST_OK || result.status == ST_BAD
            || result.status == ST_METHOD || result.status == ST_NOTIMPL
            || result.status == ST_VERSION))
        else $error("status code out of range");

endmodule

bind http_request_line_parser hrlp_checker u_hrlp_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .pop    (pop),
    .empty  (empty),
    .result (result)
);

### bench/tb_http_request_line_parser.sv
`timescale 1ns / 100ps

module tb_http_request_line_parser;
    import hrlp_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_WORDS  = 1150;
    localparam int IDLE_PERCENT  = 36;
    localparam int TAIL_CYCLES   = 10;
    // Words accepted inside this window see no idling on either side
    localparam int STEADY_FIRST  = 400;
    localparam int STEADY_LAST   = 650;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    logic     clk;
    logic     rst_n;
    logic     push = 1'b0;
    request_t request = '0;
    logic     full;
    logic     pop = 1'b0;
    result_t  result;
    logic     empty;

    // Words waiting to be driven, and results predicted for accepted words
    request_t pending_words[$];
    result_t  expected_results[$];
    logic [7:0] line_bytes[$];

    int cycles = 0;
    int words_in = 0;
    int errors = 0;
    int queued_words = 0;
    logic steady;

    // Predictor copy of the line state
    phase_t     line_phase = PH_BEFORE_M;
    logic [3:0] tok_pos    = 4'd0;
    logic       tok_match  = 1'b1;
    status_t    line_err   = ST_OK;

    http_request_line_parser DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .request (request),
        .full    (full),
        .pop     (pop),
        .result  (result),
        .empty   (empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    assign steady = (words_in >= STEADY_FIRST) && (words_in < STEADY_LAST);

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Advance the fixed-token matcher (method or version) by one byte;
    // once a byte misses, the token stays mismatched until it restarts.
    function automatic void match_token_byte(logic [7:0] c, bit is_version);
        int         len;
        logic [7:0] want;
        len  = is_version ? VERSION_LEN : METHOD_LEN;
        want = 8'h00;
        if (tok_pos < len)
            want = is_version ? VERSION_TEXT[tok_pos] : METHOD_TEXT[tok_pos];
        if (tok_match && tok_pos < len && c == want)
            tok_pos = tok_pos + 4'd1;
        else
            tok_match = 1'b0;
    endfunction

    function automatic bit token_complete(int len);
        return tok_match && (tok_pos == len);
    endfunction

    // End of string with no error latched yet: decide the status from the
    // token we stopped in. A complete method alone is still a bad request.
    function automatic void close_line();
        case (line_phase)
            PH_IN_M:
                line_err = token_complete(METHOD_LEN) ? ST_BAD : ST_METHOD;
            PH_IN_V:
                if (!token_complete(VERSION_LEN))
                    line_err = ST_VERSION;
            PH_AFTER_V: ;
            default:
                line_err = ST_BAD;
        endcase
        line_phase = PH_ENDED;
    endfunction

    // Compute the result word for one accepted request word
    function automatic result_t parse_byte(request_t req);
        result_t res;
        res = '0;
        if (line_err == ST_OK && line_phase != PH_ENDED)
        begin
            if (req.ch == CH_ZERO)
            begin
                close_line();
            end
            else if (req.ch == CH_SPACE)
            begin
                // Spaces only matter when they end a token
                case (line_phase)
                    PH_IN_M:
                    begin
                        if (!token_complete(METHOD_LEN))
                            line_err = ST_METHOD;
                        line_phase = PH_BEFORE_P;
                    end
                    PH_IN_P, PH_IN_Q:
                        line_phase = PH_BEFORE_V;
                    PH_IN_V:
                    begin
                        if (!token_complete(VERSION_LEN))
                            line_err = ST_VERSION;
                        line_phase = PH_AFTER_V;
                    end
                    default: ;
                endcase
            end
            else
            begin
                case (line_phase)
                    PH_BEFORE_M:
                    begin
                        line_phase = PH_IN_M;
                        tok_match  = 1'b1;
                        tok_pos    = 4'd0;
                        match_token_byte(req.ch, 1'b0);
                    end
                    PH_IN_M:
                        match_token_byte(req.ch, 1'b0);
                    PH_BEFORE_P:
                    begin
                        // Only origin-form targets are accepted
                        if (req.ch != CH_SLASH)
                            line_err = ST_NOTIMPL;
                        else
                        begin
                            res.out_kind = KIND_PATH;
                            res.out_char = req.ch;
                            line_phase   = PH_IN_P;
                        end
                    end
                    PH_IN_P:
                    begin
                        if (req.ch == CH_QUOTE)
                            line_err = ST_BAD;
                        else if (req.ch == CH_QMARK)
                            line_phase = PH_IN_Q;
                        else
                        begin
                            res.out_kind = KIND_PATH;
                            res.out_char = req.ch;
                        end
                    end
                    PH_IN_Q:
                    begin
                        // A second question mark is plain query text
                        if (req.ch == CH_QUOTE)
                            line_err = ST_BAD;
                        else
                        begin
                            res.out_kind = KIND_QUERY;
                            res.out_char = req.ch;
                        end
                    end
                    PH_BEFORE_V:
                    begin
                        line_phase = PH_IN_V;
                        tok_match  = 1'b1;
                        tok_pos    = 4'd0;
                        match_token_byte(req.ch, 1'b1);
                    end
                    PH_IN_V:
                        match_token_byte(req.ch, 1'b1);
                    default: ;
                endcase
            end
        end

        // Last byte: report the status and start over for the next line
        if (req.last)
        begin
            if (line_err == ST_OK && line_phase != PH_ENDED)
                close_line();
            res.done_res = 1'b1;
            res.status   = line_err;
            line_phase   = PH_BEFORE_M;
            tok_pos      = 4'd0;
            tok_match    = 1'b1;
            line_err     = ST_OK;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Line builders
    // ------------------------------------------------------------------

    function automatic void add_byte(logic [7:0] b);
        line_bytes.push_back(b);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endfunction

    // Token separator: usually one space, sometimes a run of them
    function automatic void add_gap();
        repeat (($urandom_range(3) == 0) ? $urandom_range(2, 3) : 1)
            line_bytes.push_back(CH_SPACE);
    endfunction

    // Any byte that stays inside a path or query token
    function automatic logic [7:0] path_byte();
        logic [7:0] b;
        do
            b = ($urandom_range(99) < 70) ? 8'($urandom_range(33, 126))
                                           : 8'($urandom_range(1, 255));
        while (b == CH_SPACE || b == CH_QUOTE || b == CH_QMARK);
        return b;
    endfunction

    // Turn the built line into request words, last flag on the final byte
    function automatic void commit_line();
        request_t w;
        foreach (line_bytes[i])
        begin
            w.ch   = line_bytes[i];
            w.last = (i == line_bytes.size() - 1);
            pending_words.push_back(w);
        end
        queued_words += line_bytes.size();
        line_bytes.delete();
    endfunction

    // Mostly well-formed lines with random content; the rest is noise,
    // wrong tokens, truncation, stray quotes and early zero bytes.
    function automatic void build_random_line();
        int pos;
        line_bytes.delete();
        if ($urandom_range(99) < 12)
        begin
            repeat ($urandom_range(1, 12))
                add_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0)
                add_byte(CH_SPACE);
            case ($urandom_range(19))
                0:       add_text("GE");
                1:       add_text("GETS");
                2:       add_text("POST");
                3:       add_text("get");
                default: add_text("GET");
            endcase
            add_gap();
            if ($urandom_range(19) == 0)
                add_byte(8'($urandom_range(1, 255)));
            else
                add_byte(CH_SLASH);
            repeat ($urandom_range(0, 5))
                add_byte(path_byte());
            if ($urandom_range(99) < 45)
            begin
                add_byte(CH_QMARK);
                repeat ($urandom_range(0, 5))
                    add_byte(($urandom_range(3) == 0) ? CH_QMARK : path_byte());
            end
            add_gap();
            case ($urandom_range(19))
                0:
                begin
                    add_text("HTTP/1.0");
                    add_byte(CH_CR);
                    add_byte(CH_LF);
                end
                1:
                begin
                    add_text("HTTP/1.1");
                    add_byte(CH_CR);
                end
                2:
                    add_text("HTTP/1.1");
                3:
                begin
                    add_text("HTTP/1.1");
                    add_byte(CH_CR);
                    add_byte(CH_LF);
                    add_byte(CH_LF);
                end
                default:
                begin
                    add_text("HTTP/1.1");
                    add_byte(CH_CR);
                    add_byte(CH_LF);
                end
            endcase
            // Trailing tokens are ignored
            if ($urandom_range(6) == 0)
            begin
                add_gap();
                add_text("x-y");
            end
            if ($urandom_range(4) == 0)
            begin
                pos = $urandom_range(0, line_bytes.size() - 1);
                case ($urandom_range(3))
                    0: line_bytes[pos] = 8'($urandom_range(0, 255));
                    1: line_bytes.insert(pos, CH_QUOTE);
                    2: line_bytes = line_bytes[0:pos];
                    default: line_bytes.insert(pos, CH_ZERO);
                endcase
            end
            // Zero terminator with junk after it before the last byte
            if ($urandom_range(9) == 0)
            begin
                add_byte(CH_ZERO);
                repeat ($urandom_range(0, 3))
                    add_byte(8'($urandom_range(0, 255)));
            end
        end
        commit_line();
    endfunction

    // Hold until the queue is drained and every result has come back
    task automatic wait_idle();
        while (pending_words.size() != 0 || push || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: present words from the pending queue, predict on acceptance
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push    <= 1'b0;
            request <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                expected_results.push_back(parse_byte(request));
                words_in <= words_in + 1;
            end
            // Hold a word that was refused; otherwise maybe idle
            if (push && full)
                ;
            else if (pending_words.size() != 0 &&
                     (steady || $urandom_range(99) >= IDLE_PERCENT))
            begin
                push    <= 1'b1;
                request <= pending_words.pop_front();
            end
            else
                push <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each popped result word with the oldest prediction
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h",
                 cycles, what, got, want);
        errors++;
    endtask

    task automatic check_result(result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result word with nothing expected", 8'(got), 8'h00);
            return;
        end
        want = expected_results.pop_front();
        if (got.out_char !== want.out_char)
            report_mismatch("out_char", got.out_char, want.out_char);
        if (got.out_kind !== want.out_kind)
            report_mismatch("out_kind", 8'(got.out_kind), 8'(want.out_kind));
        if (got.done_res !== want.done_res)
            report_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
        if (got.status !== want.status)
            report_mismatch("status", 8'(got.status), 8'(want.status));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
                check_result(result);
            pop <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Watchdog: a hung handshake or a lost result ends here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("http_request_line_parser regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: a good line with path, query and a second '?',
        // a bare zero byte, a top byte as method, a line of one space
        add_text("GET /a?b? HTTP/1.1");
        add_byte(CH_CR);
        add_byte(CH_LF);
        commit_line();
        add_byte(CH_ZERO);
        commit_line();
        add_byte(8'hFF);
        commit_line();
        add_byte(CH_SPACE);
        commit_line();
        wait_idle();

        // Random lines, with one full drain in the middle
        queued_words = 0;
        while (queued_words < RANDOM_WORDS / 2)
            build_random_line();
        wait_idle();
        while (queued_words < RANDOM_WORDS)
            build_random_line();
        wait_idle();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never returned", 8'(expected_results.size()), 8'h00);

        if (errors == 0)
            $display("http_request_line_parser regression: pass");
        else
            $display("http_request_line_parser regression: fail");
        $finish;
    end

endmodule
